[rtl/ple_pkg.sv]
package ple_pkg;

  // Ratio scale and derived widths of the exact product lost * scale
  localparam int unsigned LOSS_SCALE = 65536;
  localparam int unsigned SCALE_W    = $clog2(LOSS_SCALE + 1);
  localparam int unsigned PROD_W     = 32 + SCALE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W + 1);

  // Wrap window of the millisecond clock and register reset value
  localparam logic [31:0] TIME_WINDOW    = 32'd86400000;
  localparam logic [31:0] INTERVAL_RESET = 32'd10000;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_UPD1  = 7'b0010000,
    S_UPD2  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/ple_in_if.sv]
interface ple_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_time;
  logic [15:0] sent_increment;
  logic [15:0] lost_increment;

  modport source (output valid, output now_time, output sent_increment,
                  output lost_increment, input ready);
  modport sink   (input valid, input now_time, input sent_increment,
                  input lost_increment, output ready);
endinterface

[rtl/ple_out_if.sv]
interface ple_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] loss_out;
  logic [31:0] spread_out;
  logic        window_closed;

  modport source (output valid, output loss_out, output spread_out,
                  output window_closed, input ready);
  modport sink   (input valid, input loss_out, input spread_out,
                  input window_closed, output ready);
endinterface

[rtl/packet_loss_estimator_core.sv]
// Packet loss estimator.
// req carries one time update per request: now_time (ms), sent_increment
// and lost_increment. rsp returns exactly one result per request: the
// smoothed loss (loss_out, scaled by LOSS_SCALE), its mean deviation
// (spread_out) and window_closed, set when the request closed an interval.
// cfg_we_i / cfg_wdata_i write loss_interval; write it only while idle.
// One request is in work at a time; req.ready is high only when the
// sequencer is idle. A request that does not close an interval passes
// through the check and compare steps to the final step (the compare
// step is skipped when no epoch is held yet); one that closes it waits
// for the restoring divider, which resolves one quotient bit of the
// 49-bit product lost * scale per cycle, then takes two update steps.
// rsp is held in an output register: a new request is accepted while a
// result waits, and the sequencer holds in its final step until the
// receiver has taken the previous result.
// Reset clears the epoch, the counters, the estimate and the spread, sets
// loss_interval to 10000 and drops any pending result.
module packet_loss_estimator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  ple_in_if.sink       req,
  ple_out_if.source    rsp
);
  import ple_pkg::*;

  state_e      state_q, state_d;
  logic [31:0] interval_q;
  logic [31:0] epoch_q, epoch_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] lost_q, lost_d;
  logic [31:0] est_q, est_d;
  logic [31:0] spread_q, spread_d;
  logic [31:0] now_q, now_d;
  logic [31:0] tdiff_q, tdiff_d;
  logic [31:0] ratio_q, ratio_d;
  logic [31:0] diff_q, diff_d;
  logic        up_q, up_d;
  logic        closed_q, closed_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_loss_q, out_loss_d;
  logic [31:0] out_spread_q, out_spread_d;
  logic        out_closed_q, out_closed_d;

  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  div_status_t       div_status;
  logic [31:0]       div_quotient;

  logic [32:0] sent_sum, lost_sum;
  logic [31:0] fwd_diff, back_diff;
  logic [32:0] spread_sum;
  logic        in_fire, out_free;

  assign in_fire  = req.valid && req.ready;
  assign out_free = !out_valid_q || rsp.ready;

  assign sent_sum     = {1'b0, sent_q} + 33'(req.sent_increment);
  assign lost_sum     = {1'b0, lost_q} + 33'(req.lost_increment);
  assign fwd_diff     = now_q - epoch_q;
  assign back_diff    = epoch_q - now_q;
  assign spread_sum   = {1'b0, spread_q} - {3'b000, spread_q[31:2]}
                      + {3'b000, diff_q[31:2]};
  assign div_dividend = PROD_W'(lost_q) * PROD_W'(LOSS_SCALE);

  ple_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (sent_q),
    .status_o   (div_status),
    .quotient_o (div_quotient)
  );

  // Sequencer
  always_comb begin
    state_d      = state_q;
    epoch_d      = epoch_q;
    sent_d       = sent_q;
    lost_d       = lost_q;
    est_d        = est_q;
    spread_d     = spread_q;
    now_d        = now_q;
    tdiff_d      = tdiff_q;
    ratio_d      = ratio_q;
    diff_d       = diff_q;
    up_d         = up_q;
    closed_d     = closed_q;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_loss_d   = out_loss_q;
    out_spread_d = out_spread_q;
    out_closed_d = out_closed_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // Accumulate with saturation and hold the time
          sent_d   = sent_sum[32] ? '1 : sent_sum[31:0];
          lost_d   = lost_sum[32] ? '1 : lost_sum[31:0];
          now_d    = req.now_time;
          closed_d = 1'b0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (epoch_q == '0) begin
          epoch_d = now_q;
          state_d = S_FIN;
        end else begin
          tdiff_d = (fwd_diff >= TIME_WINDOW) ? back_diff : fwd_diff;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (tdiff_q >= interval_q && sent_q != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          ratio_d = div_quotient;
          state_d = S_UPD1;
        end
      end
      S_UPD1: begin
        up_d    = ratio_q >= est_q;
        diff_d  = (ratio_q >= est_q) ? (ratio_q - est_q) : (est_q - ratio_q);
        state_d = S_UPD2;
      end
      S_UPD2: begin
        // Move estimate by an eighth; decay and refill the spread
        est_d    = up_q ? (est_q + {3'b000, diff_q[31:3]})
                        : (est_q - {3'b000, diff_q[31:3]});
        spread_d = spread_sum[32] ? '1 : spread_sum[31:0];
        epoch_d  = now_q;
        sent_d   = '0;
        lost_d   = '0;
        closed_d = 1'b1;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_loss_d   = est_q;
          out_spread_d = spread_q;
          out_closed_d = closed_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      interval_q  <= INTERVAL_RESET;
      epoch_q     <= '0;
      sent_q      <= '0;
      lost_q      <= '0;
      est_q       <= '0;
      spread_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      sent_q      <= sent_d;
      lost_q      <= lost_d;
      est_q       <= est_d;
      spread_q    <= spread_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    tdiff_q      <= tdiff_d;
    ratio_q      <= ratio_d;
    diff_q       <= diff_d;
    up_q         <= up_d;
    closed_q     <= closed_d;
    out_loss_q   <= out_loss_d;
    out_spread_q <= out_spread_d;
    out_closed_q <= out_closed_d;
  end

  assign req.ready         = (state_q == S_IDLE);
  assign rsp.valid         = out_valid_q;
  assign rsp.loss_out      = out_loss_q;
  assign rsp.spread_out    = out_spread_q;
  assign rsp.window_closed = out_closed_q;

endmodule

[rtl/ple_divider.sv]
module ple_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ple_pkg::PROD_W-1:0]   dividend_i,
  input  logic [31:0]                  divisor_i,
  output ple_pkg::div_status_t         status_o,
  output logic [31:0]                  quotient_o
);
  import ple_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d;
  logic [PROD_W-1:0]    work_q, work_d;
  logic [31:0]          divisor_q, divisor_d;
  logic [32:0]          trial;
  logic [33:0]          diff;
  logic                 qbit;

  // Shift in the next dividend bit and try one subtraction
  assign trial = {rem_q, work_q[PROD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor_q};
  assign qbit  = ~diff[33];

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    work_d    = work_q;
    divisor_d = divisor_q;
    if (start_i && !busy_q) begin
      busy_d    = 1'b1;
      cnt_d     = DIV_CNT_W'(PROD_W);
      rem_d     = '0;
      work_d    = dividend_i;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      // Restoring step: quotient bits fill in from the right
      rem_d  = qbit ? diff[31:0] : trial[31:0];
      work_d = {work_q[PROD_W-2:0], qbit};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    work_q    <= work_d;
    divisor_q <= divisor_d;
  end

  // Saturate quotients that do not fit in 32 bits
  assign quotient_o    = (|work_q[PROD_W-1:32]) ? '1 : work_q[31:0];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

[rtl/ple_checker.sv]
module ple_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_loss_i,
  input  logic [31:0] out_spread_i,
  input  logic        out_closed_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_loss_i) && $stable(out_spread_i) && $stable(out_closed_i))
    else $error("result changed while stalled");

  // Take one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // A result rises only after the sequencer has worked on its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind packet_loss_estimator_core ple_checker u_ple_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req.valid),
  .in_ready_i   (req.ready),
  .out_valid_i  (rsp.valid),
  .out_ready_i  (rsp.ready),
  .out_loss_i   (rsp.loss_out),
  .out_spread_i (rsp.spread_out),
  .out_closed_i (rsp.window_closed)
);

[verif/packet_loss_estimator_core_test.sv]
`timescale 1ns / 100ps

module packet_loss_estimator_core_test;
  import ple_pkg::LOSS_SCALE;
  import ple_pkg::TIME_WINDOW;
  import ple_pkg::INTERVAL_RESET;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SOAK_ITEMS      = 64;
  localparam int unsigned ITEMS_PER_PHASE = 175;
  localparam int unsigned LINGER_CYCLES   = 8;

  typedef struct packed {
    logic [31:0] loss;
    logic [31:0] spread;
    logic        closed;
  } loss_result_t;

  // One time update, with an optional hand-typed result
  typedef struct packed {
    logic [31:0]  now;
    logic [15:0]  sent;
    logic [15:0]  lost;
    logic         fixed;
    loss_result_t want;
  } update_t;

  // Directed requests; reset interval of 10000 ms is in force
  localparam update_t DIRECTED_PLAN [18] = '{
    // no epoch held, time zero keeps it empty
    '{32'd0,            16'd0,     16'd0,     1'b1, '{32'd0,    32'd0,     1'b0}},
    // first epoch
    '{32'd1000,         16'd100,   16'd0,     1'b1, '{32'd0,    32'd0,     1'b0}},
    // interval not reached
    '{32'd5000,         16'd0,     16'd0,     1'b1, '{32'd0,    32'd0,     1'b0}},
    // interval reached exactly, no loss
    '{32'd11000,        16'd0,     16'd0,     1'b1, '{32'd0,    32'd0,     1'b1}},
    // full loss: estimate moves an eighth, spread a quarter
    '{32'd21000,        16'd100,   16'd100,   1'b1, '{32'd8192, 32'd16384, 1'b1}},
    // nothing sent: no update
    '{32'd31000,        16'd0,     16'd0,     1'b1, '{32'd8192, 32'd16384, 1'b0}},
    // loss far above sent: ratio saturates
    '{32'd31001,        16'd0,     16'hFFFF,  1'b0, '0},
    '{32'd41001,        16'd1,     16'hFFFF,  1'b0, '0},
    // time jumps: reversed difference, forward wrap, small and large step back
    '{32'hFFFF_F000,    16'd10,    16'd1,     1'b0, '0},
    '{32'h0000_2000,    16'd5,     16'd5,     1'b0, '0},
    '{32'h0000_1000,    16'd7,     16'd0,     1'b0, '0},
    '{32'hFFFF_0000,    16'd3,     16'hFFFF,  1'b0, '0},
    // close at time zero, which drops the epoch
    '{32'd0,            16'hFFFF,  16'd0,     1'b0, '0},
    '{32'hFFFF_FFFF,    16'hFFFF,  16'hFFFF,  1'b0, '0},
    // difference of exactly the window, then one below it
    '{32'd86399999,     16'd1,     16'd0,     1'b0, '0},
    '{32'd172799998,    16'd2,     16'd1,     1'b0, '0},
    // one below the interval, then exactly on it
    '{32'd172809997,    16'd4,     16'd4,     1'b0, '0},
    '{32'd172809998,    16'd0,     16'd0,     1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  ple_in_if  req_if ();
  ple_out_if rsp_if ();

  packet_loss_estimator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  // Estimator copy: epoch, counters, estimate, spread and interval
  logic [31:0] epoch_ms;
  logic [31:0] sent_total;
  logic [31:0] lost_total;
  logic [31:0] loss_est;
  logic [31:0] loss_dev;
  logic [31:0] interval_ms;

  loss_result_t expected_estimates [$];
  int unsigned  mismatches;
  logic         req_fixed;
  loss_result_t req_fixed_result;
  bit           sender_calm;
  bit           receiver_calm;
  logic [31:0]  stim_ms;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Fold one request into the estimator copy and return its result
  task automatic predict_loss_update(input update_t u, output loss_result_t r);
    logic [32:0] sum;
    logic [31:0] gap;
    logic [63:0] prod;
    logic [63:0] quo;
    logic [31:0] ratio;
    logic [31:0] delta;
    logic [32:0] dev;

    sum        = {1'b0, sent_total} + {17'd0, u.sent};
    sent_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    sum        = {1'b0, lost_total} + {17'd0, u.lost};
    lost_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    r.closed   = 1'b0;

    if (epoch_ms == 32'd0) begin
      epoch_ms = u.now;
    end else begin
      // treat a difference at or past the window as time running backward
      gap = u.now - epoch_ms;
      if (gap >= TIME_WINDOW) begin
        gap = epoch_ms - u.now;
      end
      if (gap >= interval_ms && sent_total != 32'd0) begin
        prod  = {32'd0, lost_total} * 64'(LOSS_SCALE);
        quo   = prod / {32'd0, sent_total};
        ratio = (quo > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
        dev   = {1'b0, loss_dev} - {3'd0, loss_dev[31:2]};
        if (ratio >= loss_est) begin
          delta    = ratio - loss_est;
          loss_est = loss_est + (delta >> 3);
        end else begin
          delta    = loss_est - ratio;
          loss_est = loss_est - (delta >> 3);
        end
        dev        = dev + {3'd0, delta[31:2]};
        loss_dev   = dev[32] ? 32'hFFFF_FFFF : dev[31:0];
        epoch_ms   = u.now;
        sent_total = 32'd0;
        lost_total = 32'd0;
        r.closed   = 1'b1;
      end
    end
    r.loss   = loss_est;
    r.spread = loss_dev;
  endtask

  // Check each result, then predict each accepted request
  always @(posedge clk_i) begin : scoreboard
    loss_result_t got;
    loss_result_t want;
    update_t      u;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.loss_out, rsp_if.spread_out, rsp_if.window_closed};
        if (expected_estimates.size() == 0) begin
          flag_mismatch("result with none pending", got.loss, 32'd0);
        end else begin
          want = expected_estimates.pop_front();
          if (got.loss !== want.loss) flag_mismatch("loss_out", got.loss, want.loss);
          if (got.spread !== want.spread) begin
            flag_mismatch("spread_out", got.spread, want.spread);
          end
          if (got.closed !== want.closed) begin
            flag_mismatch("window_closed", {31'd0, got.closed}, {31'd0, want.closed});
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        u = '0;
        u.now  = req_if.now_time;
        u.sent = req_if.sent_increment;
        u.lost = req_if.lost_increment;
        predict_loss_update(u, want);
        expected_estimates.insert(expected_estimates.size(),
                                  req_fixed ? req_fixed_result : want);
      end
    end
  end

  // Drive rsp.ready with random stall bursts
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!receiver_calm && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 14) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[packet_loss_estimator_core] ERROR");
    $finish;
  end

  // Present one request, after an optional random gap, and hold it until taken
  task automatic send_update(input update_t u);
    if (!sender_calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.now_time       <= u.now;
    req_if.sent_increment <= u.sent;
    req_if.lost_increment <= u.lost;
    req_fixed             <= u.fixed;
    req_fixed_result      <= u.want;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle_pipeline();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_estimates.size() != 0);
    repeat (LINGER_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_interval(input logic [31:0] iv);
    settle_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= iv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    interval_ms = iv;
  endtask

  // Mostly advance time around the interval; sometimes jump, step back or hit zero
  task automatic make_update(input logic [31:0] iv, output update_t u);
    int unsigned pick;
    logic [31:0] span;
    u    = '0;
    span = (iv > 32'd40000000) ? 32'd90000000 : (iv << 1) + 32'd16;
    pick = $urandom_range(0, 19);
    case (pick)
      0: begin
        stim_ms = $urandom();
      end
      1: begin
        stim_ms = 32'd0;
      end
      2: begin
        stim_ms = stim_ms - $urandom_range(0, span);
      end
      default: begin
        stim_ms = stim_ms + $urandom_range(0, span);
      end
    endcase
    u.now = stim_ms;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      u.sent = 16'($urandom());
      u.lost = 16'($urandom());
    end else if (pick == 1) begin
      u.sent = 16'd0;
      u.lost = 16'($urandom_range(0, 50));
    end else begin
      u.sent = 16'($urandom_range(0, 2000));
      u.lost = 16'($urandom_range(0, u.sent / 4 + 8));
    end
  endtask

  initial begin : stimulus
    update_t     u;
    logic [31:0] phase_ivs [8];

    epoch_ms      = 32'd0;
    sent_total    = 32'd0;
    lost_total    = 32'd0;
    loss_est      = 32'd0;
    loss_dev      = 32'd0;
    interval_ms   = INTERVAL_RESET;
    mismatches    = 0;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    stim_ms       = 32'd0;

    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_wdata_i           <= 32'd0;
    req_if.valid          <= 1'b0;
    req_if.now_time       <= 32'd0;
    req_if.sent_increment <= 16'd0;
    req_if.lost_increment <= 16'd0;
    req_fixed             <= 1'b0;
    req_fixed_result      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_PLAN[i]) begin
      send_update(DIRECTED_PLAN[i]);
    end

    // Pile large counts into both counters with no window able to close
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    set_interval(32'hFFFF_FFFF);
    u      = '0;
    u.now  = 32'd12345;
    u.sent = 16'hFFFF;
    u.lost = 16'hFFFF;
    repeat (SOAK_ITEMS) send_update(u);
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    stim_ms       = 32'd12345;

    // Random phases; the zero interval first closes the accumulated window
    phase_ivs = '{32'd0, 32'd1, 32'd250, 32'd5000, 32'($urandom_range(2, 200000)),
                  32'd86399999, 32'hFFFF_FFFF, INTERVAL_RESET};
    foreach (phase_ivs[p]) begin
      set_interval(phase_ivs[p]);
      if (p == 7) begin
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        make_update(phase_ivs[p], u);
        send_update(u);
      end
    end

    settle_pipeline();
    if (mismatches == 0) begin
      $display("[packet_loss_estimator_core] OK");
    end else begin
      $display("[packet_loss_estimator_core] ERROR");
    end
    $finish;
  end

endmodule
